// ----- src/rrbs_pkg.sv -----
// Shared types, codes and defaults for the round-robin banked stack block.
// No dependencies; rrbs_front, rrbs_back and the top level import this package.
`default_nettype none

package rrbs_pkg;

    // Build-time defaults for the top-level parameters
    localparam int MAX_BANKS_DEF  = 8;
    localparam int BANK_DEPTH_DEF = 64;

    // Depth of the command and result queues
    localparam int QUEUE_DEPTH = 2;

    // Field widths fixed by the interface
    localparam int CODE_W     = 16;
    localparam int KIND_W     = 4;
    localparam int VALUE_W    = 32;
    localparam int SEL_W      = 3;
    localparam int NBANKS_W   = 4;
    localparam int CAP_W      = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BANKS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_CAPACITY = 1'b1;

    // Register reset values
    localparam logic [NBANKS_W-1:0] NUM_BANKS_RST     = 4'd8;
    localparam logic [CAP_W-1:0]    BANK_CAPACITY_RST = 7'd64;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_PUSHED   = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_ALL_FULL = 2'd3
    } status_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_READ = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } record_t;

    // Decoded command word, front to back
    typedef struct packed {
        op_t              op;
        logic             sel_ok;
        logic [SEL_W-1:0] sel;
        record_t          rec;
    } cmd_t;

    // Result word, back to result queue
    typedef struct packed {
        status_t          status;
        logic [SEL_W-1:0] bank_used;
        record_t          rec;
    } res_t;

endpackage

`default_nettype wire

// ----- src/rrbs_queue.sv -----
// Small first-in first-out queue of generic words.
// Depends on nothing but its parameters.
`default_nettype none

module rrbs_queue #(
    parameter type word_t = logic,
    parameter int  DEPTH  = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr,
    input  wire word_t wr_word,
    output logic       full,
    input  wire logic  rd,
    output word_t      rd_word,
    output logic       valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    word_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && valid;
    assign rd_word = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

`default_nettype wire

// ----- src/rrbs_front.sv -----
// Front end: takes input words, decodes them and queues the commands.
// Depends on rrbs_pkg and rrbs_queue.
`default_nettype none

module rrbs_front
    import rrbs_pkg::*;
#(
    parameter int MAX_BANKS = MAX_BANKS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               operation,
    input  wire logic [SEL_W-1:0]   bank_select,
    input  wire logic [CODE_W-1:0]  record_code,
    input  wire logic [KIND_W-1:0]  record_kind,
    input  wire logic [VALUE_W-1:0] record_value,
    output logic                    cmd_valid,
    output cmd_t                    cmd_word,
    input  wire logic               cmd_take
);

    cmd_t decoded;

    // Bank numbers past the last bank built are flagged here so the back
    // end answers them as empty without looking at any fill count.
    always_comb
    begin
        decoded.op        = op_t'(operation);
        decoded.sel_ok    = (32'(bank_select) < MAX_BANKS);
        decoded.sel       = bank_select;
        decoded.rec.code  = record_code;
        decoded.rec.kind  = record_kind;
        decoded.rec.value = record_value;
    end

    rrbs_queue #(
        .word_t (cmd_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_word (decoded),
        .full    (full),
        .rd      (cmd_take),
        .rd_word (cmd_word),
        .valid   (cmd_valid)
    );

endmodule

`default_nettype wire

// ----- src/rrbs_back.sv -----
// Back end: fill counts, round-robin bank choice, record memory, config.
// Depends on rrbs_pkg.
`default_nettype none

module rrbs_back
    import rrbs_pkg::*;
#(
    parameter int MAX_BANKS  = MAX_BANKS_DEF,
    parameter int BANK_DEPTH = BANK_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  cmd_valid,
    input  wire cmd_t                  cmd_word,
    output logic                       cmd_take,
    input  wire logic                  res_full,
    output logic                       res_valid,
    output res_t                       res_word
);

    localparam int BANK_W    = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int FILL_W    = $clog2(BANK_DEPTH + 1);
    localparam int MEM_DEPTH = MAX_BANKS * BANK_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    back_state_t        state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg [MAX_BANKS];
    logic [FILL_W-1:0]  fill_next [MAX_BANKS];
    logic [BANK_W-1:0]  next_bank_reg, next_bank_next;
    logic [SEL_W-1:0]   pend_bank_reg, pend_bank_next;
    logic [NBANKS_W-1:0] num_banks_reg;
    logic [CAP_W-1:0]   bank_capacity_reg;

    record_t            mem [MEM_DEPTH];
    record_t            rd_data_reg;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_addr;

    logic [BANK_W:0]    eff_n;
    logic [FILL_W-1:0]  eff_cap;
    logic [BANK_W-1:0]  start;
    logic [MAX_BANKS-1:0] ok;
    logic               hit_hi, hit_any;
    logic [BANK_W-1:0]  win_hi, win_lo, win;
    logic [BANK_W:0]    win_inc;
    logic [BANK_W-1:0]  after_win;
    logic [FILL_W-1:0]  win_fill, sel_fill;
    logic [31:0]        win_wide, sel_wide;
    logic [BANK_W-1:0]  sel_idx;
    logic               pop_empty;
    logic [ADDR_W-1:0]  push_addr, pop_addr;

    // Clamp the register values to the range the hardware supports
    always_comb
    begin
        int nb_i;
        int cap_i;
        nb_i  = int'(num_banks_reg);
        cap_i = int'(bank_capacity_reg);
        if (nb_i < 1)
            nb_i = 1;
        else if (nb_i > MAX_BANKS)
            nb_i = MAX_BANKS;
        if (cap_i < 1)
            cap_i = 1;
        else if (cap_i > BANK_DEPTH)
            cap_i = BANK_DEPTH;
        eff_n   = (BANK_W + 1)'(nb_i);
        eff_cap = FILL_W'(cap_i);
    end

    // Round-robin choice: first open bank at or after start, else the
    // first open bank from zero.
    always_comb
    begin
        start   = ({1'b0, next_bank_reg} < eff_n) ? next_bank_reg : '0;
        hit_hi  = 1'b0;
        hit_any = 1'b0;
        win_hi  = '0;
        win_lo  = '0;
        for (int b = MAX_BANKS - 1; b >= 0; b--)
        begin
            ok[b] = ((BANK_W + 1)'(b) < eff_n) && (fill_reg[b] < eff_cap);
            if (ok[b])
            begin
                hit_any = 1'b1;
                win_lo  = BANK_W'(b);
                if (BANK_W'(b) >= start)
                begin
                    hit_hi = 1'b1;
                    win_hi = BANK_W'(b);
                end
            end
        end
        win       = hit_hi ? win_hi : win_lo;
        win_inc   = {1'b0, win} + 1'b1;
        after_win = (win_inc >= eff_n) ? '0 : win_inc[BANK_W-1:0];
        win_wide  = 32'(win);
    end

    always_comb
    begin
        sel_wide = 32'(cmd_word.sel);
        sel_idx  = sel_wide[BANK_W-1:0];
        win_fill = '0;
        sel_fill = '0;
        for (int b = 0; b < MAX_BANKS; b++)
        begin
            if (win == BANK_W'(b))
                win_fill = fill_reg[b];
            if (sel_idx == BANK_W'(b))
                sel_fill = fill_reg[b];
        end
        pop_empty = !cmd_word.sel_ok || (sel_fill == '0);
        push_addr = ADDR_W'(32'(win) * BANK_DEPTH + 32'(win_fill));
        pop_addr  = ADDR_W'(32'(sel_idx) * BANK_DEPTH + 32'(sel_fill) - 32'd1);
    end

    // Sequencer: a push and an empty pop finish in the idle state; a pop that
    // hits reads the memory and answers in the next cycle, from the read state.
    always_comb
    begin
        state_next     = state_reg;
        next_bank_next = next_bank_reg;
        pend_bank_next = pend_bank_reg;
        fill_next      = fill_reg;
        cmd_take       = 1'b0;
        res_valid      = 1'b0;
        res_word       = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_take = 1'b1;
                    if (cmd_word.op == OP_PUSH)
                    begin
                        res_valid = 1'b1;
                        if (hit_any)
                        begin
                            mem_we             = 1'b1;
                            mem_addr           = push_addr;
                            next_bank_next     = after_win;
                            res_word.status    = ST_PUSHED;
                            res_word.bank_used = win_wide[SEL_W-1:0];
                            for (int b = 0; b < MAX_BANKS; b++)
                            begin
                                if (win == BANK_W'(b))
                                    fill_next[b] = fill_reg[b] + 1'b1;
                            end
                        end
                        else
                        begin
                            res_word.status = ST_ALL_FULL;
                        end
                    end
                    else
                    begin
                        res_word.bank_used = cmd_word.sel;
                        if (pop_empty)
                        begin
                            res_valid       = 1'b1;
                            res_word.status = ST_EMPTY;
                        end
                        else
                        begin
                            mem_re         = 1'b1;
                            mem_addr       = pop_addr;
                            pend_bank_next = cmd_word.sel;
                            state_next     = BK_READ;
                            for (int b = 0; b < MAX_BANKS; b++)
                            begin
                                if (sel_idx == BANK_W'(b))
                                    fill_next[b] = fill_reg[b] - 1'b1;
                            end
                        end
                    end
                end
            end
            BK_READ:
            begin
                res_valid          = 1'b1;
                res_word.status    = ST_POPPED;
                res_word.bank_used = pend_bank_reg;
                res_word.rec       = rd_data_reg;
                state_next         = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            next_bank_reg <= '0;
            for (int b = 0; b < MAX_BANKS; b++)
                fill_reg[b] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            next_bank_reg <= next_bank_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_bank_reg <= pend_bank_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_banks_reg     <= NUM_BANKS_RST;
            bank_capacity_reg <= BANK_CAPACITY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_BANKS:     num_banks_reg     <= cfg_data[NBANKS_W-1:0];
                CFG_BANK_CAPACITY: bank_capacity_reg <= cfg_data[CAP_W-1:0];
            endcase
        end
    end

    // Record memory, single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= cmd_word.rec;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !res_full)
        else $error("result written into a full result queue");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |=> (state_reg == BK_IDLE))
        else $error("read state held past one cycle");

    a_read_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == BK_READ))
        else $error("memory read issued without answering it");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("memory read and write in the same cycle");

endmodule

`default_nettype wire

// ----- src/round_robin_banked_stacks.sv -----
// Timing: a push word passes the command queue and then the result queue before its result
// is on the result ports; a pop that finds a record also passes the registered memory read.
// Throughput: one push word per cycle unless a queue is full; a hitting pop holds off the next command.
// Reset: queues empty, all fill counts zero, round-robin start at bank 0, register
// num_banks 8 and bank_capacity 64. The record memory is not cleared and needs no pass.
`default_nettype none

// Top level: command front end, executing back end and a result queue.
// Depends on rrbs_pkg, rrbs_queue, rrbs_front and rrbs_back.
module round_robin_banked_stacks
    import rrbs_pkg::*;
#(
    parameter int MAX_BANKS  = MAX_BANKS_DEF,
    parameter int BANK_DEPTH = BANK_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input words
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  operation,
    input  wire logic [SEL_W-1:0]      bank_select,
    input  wire logic [CODE_W-1:0]     record_code,
    input  wire logic [KIND_W-1:0]     record_kind,
    input  wire logic [VALUE_W-1:0]    record_value,
    // result words
    output logic                       empty,
    input  wire logic                  pop,
    output logic [1:0]                 status,
    output logic [SEL_W-1:0]           bank_used,
    output logic [CODE_W-1:0]          out_code,
    output logic [KIND_W-1:0]          out_kind,
    output logic [VALUE_W-1:0]         out_value
);

    cmd_t cmd_word;
    logic cmd_valid;
    logic cmd_take;
    res_t res_word;
    logic res_valid;
    logic res_full;
    res_t head_word;
    logic head_valid;

    // Front end decodes each word and holds a short command queue, so the
    // input side keeps accepting while the back end waits on a memory read
    // or on a full result queue.
    rrbs_front #(
        .MAX_BANKS (MAX_BANKS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .bank_select  (bank_select),
        .record_code  (record_code),
        .record_kind  (record_kind),
        .record_value (record_value),
        .cmd_valid    (cmd_valid),
        .cmd_word     (cmd_word),
        .cmd_take     (cmd_take)
    );

    // Back end owns the fill counts, the round-robin pointer, the config
    // registers and the record memory; it starts a command only when the
    // result queue has a free slot.
    rrbs_back #(
        .MAX_BANKS  (MAX_BANKS),
        .BANK_DEPTH (BANK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_word  (cmd_word),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    // Result queue decouples the back end from the consumer
    rrbs_queue #(
        .word_t (res_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_valid),
        .wr_word (res_word),
        .full    (res_full),
        .rd      (pop),
        .rd_word (head_word),
        .valid   (head_valid)
    );

    assign empty     = !head_valid;
    assign status    = head_word.status;
    assign bank_used = head_word.bank_used;
    assign out_code  = head_word.rec.code;
    assign out_kind  = head_word.rec.kind;
    assign out_value = head_word.rec.value;

endmodule

`default_nettype wire
